// ----- rtl/core/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the one-wire bus master core.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int unsigned NUM_REGS   = 8;
	localparam int unsigned REG_W      = 10;
	localparam int unsigned REG_IDX_W  = 4;
	localparam int unsigned REG_SEL_W  = 3;

	localparam logic [REG_SEL_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_WR1_LOW       = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_WR1_HIGH      = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_WR0_LOW       = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_WR0_HIGH      = 3'd6;
	localparam logic [REG_SEL_W-1:0] REG_READ_SAMPLE   = 3'd7;

	typedef logic [REG_W-1:0] ticks_t;
	typedef ticks_t [NUM_REGS-1:0] reg_file_t;

	localparam reg_file_t REG_DEFAULTS = '{
		10'd10, 10'd5, 10'd65, 10'd55, 10'd10, 10'd410, 10'd70, 10'd480
	};

	localparam ticks_t READ_LOW_US  = 10'd3;
	localparam ticks_t READ_TAIL_US = 10'd53;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] MODE_REL  = 2'd0;
	localparam logic [1:0] MODE_LOW  = 2'd1;
	localparam logic [1:0] MODE_HIGH = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_WR_LOW   = 4'd4,
		PH_WR_HIGH  = 4'd5,
		PH_RD_LOW   = 4'd6,
		PH_RD_WAIT  = 4'd7,
		PH_RD_TAIL  = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		ticks_t     timer;
		logic [2:0] bit_num;
		logic [7:0] shift;
		logic       absent;
		logic [1:0] drive;
		logic [7:0] last_read;
	} bus_state_t;

	typedef struct packed {
		logic [1:0] pin_mode;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       absent;
		logic       ignored;
	} bus_result_t;

	function automatic ticks_t at_least_one(input ticks_t v);
		return (v == '0) ? ticks_t'(1) : v;
	endfunction

endpackage

// ----- rtl/core/one_wire_bus_master_core.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// Microsecond-ticked one-wire bus master: reset/presence, byte write, byte read.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall) carries one word per item: a tick of one
//   microsecond with the sampled bus_level, or a reset, write or read command.
//   Commands are taken only while idle; a command while busy is flagged with
//   command_ignored and changes nothing.
//   res channel (res_valid/res_stall) returns exactly one word per item:
//   pin_mode to drive during that microsecond, busy/done flags, the last read
//   byte and the presence result. Bytes go LSB first.
//   cfg channel (cfg_valid/cfg_ready) writes the eight 10-bit timing
//   registers; cfg_ready is always high. Write only while idle.
// Result: registered, valid in the cycle after its item is accepted.
// Throughput: one item per cycle while cmd_stall is low; the state update
//   and the result register sit behind a single layer of logic in owbm_step.
// Stall: while a result word waits under res_stall, cmd_stall is raised and
//   the word holds; no item is lost.
// Reset: timing registers return to defaults, the bus master goes idle with
//   the line released, and the result register is emptied.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core import owbm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [1:0]           operation,
	input  logic [7:0]           write_value,
	input  logic                 bus_level,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           pin_mode,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [7:0]           read_data,
	output logic                 device_absent,
	output logic                 command_ignored,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	reg_file_t   regs_q;
	bus_state_t  state_q;
	bus_state_t  state_nxt;
	bus_result_t res_nxt;
	bus_result_t res_s1;
	logic        res_valid_s1;
	logic        cmd_accept;

	assign cfg_ready  = 1'b1;
	assign cmd_stall  = res_valid_s1 & res_stall;
	assign cmd_accept = cmd_valid & ~cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REG_DEFAULTS;
		end else if (cfg_valid && cfg_ready && cfg_index < REG_IDX_W'(NUM_REGS)) begin
			regs_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	owbm_step u_step (
		.cur         (state_q),
		.regs        (regs_q),
		.operation   (operation),
		.write_value (write_value),
		.bus_level   (bus_level),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, drive: MODE_REL, default: '0};
		end else if (cmd_accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (cmd_accept) begin
			res_valid_s1 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept)
			res_s1 <= res_nxt;
	end

	assign res_valid       = res_valid_s1;
	assign pin_mode        = res_s1.pin_mode;
	assign busy_res        = res_s1.busy;
	assign done_res        = res_s1.done;
	assign read_data       = res_s1.read_data;
	assign device_absent   = res_s1.absent;
	assign command_ignored = res_s1.ignored;

endmodule

// ----- rtl/core/owbm_step.sv -----
// ----------------------------------------------------------------------------
// owbm_step
// Next-state and result logic for one command or one microsecond tick.
// ----------------------------------------------------------------------------
module owbm_step import owbm_pkg::*; (
	input  bus_state_t  cur,
	input  reg_file_t   regs,
	input  logic [1:0]  operation,
	input  logic [7:0]  write_value,
	input  logic        bus_level,
	output bus_state_t  nxt,
	output bus_result_t res
);

	logic   expired;
	ticks_t timer_dec;
	logic   cur_bit;
	logic   next_bit;
	ticks_t hi_len;

	assign expired   = (cur.timer <= ticks_t'(1));
	assign timer_dec = expired ? '0 : cur.timer - ticks_t'(1);
	assign cur_bit   = cur.shift[cur.bit_num];
	assign next_bit  = cur.shift[cur.bit_num + 3'd1];
	assign hi_len    = cur_bit ? regs[REG_WR1_HIGH] : regs[REG_WR0_HIGH];

	// next state
	always_comb begin
		nxt = cur;
		if (operation == OP_TICK) begin
			if (cur.phase != PH_IDLE) begin
				nxt.timer = timer_dec;
				unique case (cur.phase)
					PH_RST_LOW: begin
						if (expired) begin
							nxt.phase = PH_RST_WAIT;
							nxt.timer = at_least_one(regs[REG_PRESENCE_WAIT]);
							nxt.drive = MODE_REL;
						end
					end
					PH_RST_WAIT: begin
						if (expired) begin
							nxt.absent = bus_level;
							if (regs[REG_RESET_TAIL] == '0) begin
								nxt.phase   = PH_IDLE;
								nxt.timer   = '0;
								nxt.bit_num = '0;
								nxt.drive   = MODE_REL;
							end else begin
								nxt.phase = PH_RST_TAIL;
								nxt.timer = regs[REG_RESET_TAIL];
							end
						end
					end
					PH_RST_TAIL: begin
						if (expired) begin
							nxt.phase   = PH_IDLE;
							nxt.timer   = '0;
							nxt.bit_num = '0;
							nxt.drive   = MODE_REL;
						end
					end
					PH_WR_LOW, PH_WR_HIGH: begin
						if (expired) begin
							nxt.drive = MODE_HIGH;
							if (cur.phase == PH_WR_LOW && hi_len != '0) begin
								nxt.phase = PH_WR_HIGH;
								nxt.timer = hi_len;
							end else if (cur.bit_num == 3'd7) begin
								nxt.phase   = PH_IDLE;
								nxt.timer   = '0;
								nxt.bit_num = '0;
							end else begin
								nxt.bit_num = cur.bit_num + 3'd1;
								nxt.phase   = PH_WR_LOW;
								nxt.timer   = at_least_one(next_bit ? regs[REG_WR1_LOW]
								                                    : regs[REG_WR0_LOW]);
								nxt.drive   = MODE_LOW;
							end
						end
					end
					PH_RD_LOW: begin
						if (expired) begin
							nxt.phase = PH_RD_WAIT;
							nxt.timer = at_least_one(regs[REG_READ_SAMPLE]);
							nxt.drive = MODE_REL;
						end
					end
					PH_RD_WAIT: begin
						if (expired) begin
							if (bus_level)
								nxt.shift[cur.bit_num] = 1'b1;
							nxt.phase = PH_RD_TAIL;
							nxt.timer = READ_TAIL_US;
						end
					end
					PH_RD_TAIL: begin
						if (expired) begin
							if (cur.bit_num == 3'd7) begin
								nxt.last_read = cur.shift;
								nxt.phase     = PH_IDLE;
								nxt.timer     = '0;
								nxt.bit_num   = '0;
								nxt.drive     = MODE_REL;
							end else begin
								nxt.bit_num = cur.bit_num + 3'd1;
								nxt.phase   = PH_RD_LOW;
								nxt.timer   = READ_LOW_US;
								nxt.drive   = MODE_LOW;
							end
						end
					end
					default: nxt.phase = PH_IDLE;
				endcase
			end
		end else if (cur.phase == PH_IDLE) begin
			nxt.bit_num = '0;
			nxt.drive   = MODE_LOW;
			unique case (operation)
				OP_RESET: begin
					nxt.phase = PH_RST_LOW;
					nxt.timer = at_least_one(regs[REG_RESET_LOW]);
				end
				OP_WRITE: begin
					nxt.shift = write_value;
					nxt.phase = PH_WR_LOW;
					nxt.timer = at_least_one(write_value[0] ? regs[REG_WR1_LOW]
					                                        : regs[REG_WR0_LOW]);
				end
				default: begin
					nxt.shift = '0;
					nxt.phase = PH_RD_LOW;
					nxt.timer = READ_LOW_US;
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res.pin_mode  = (operation == OP_TICK) ? cur.drive : nxt.drive;
		res.busy      = (operation != OP_TICK) || (cur.phase != PH_IDLE);
		res.done      = (operation == OP_TICK) && (cur.phase != PH_IDLE) &&
		                (nxt.phase == PH_IDLE);
		res.read_data = nxt.last_read;
		res.absent    = nxt.absent;
		res.ignored   = (operation != OP_TICK) && (cur.phase != PH_IDLE);
	end

endmodule

// ----- rtl/core/owbm_checker.sv -----
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks for the one-wire bus master core.
// ----------------------------------------------------------------------------
module owbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] pin_mode,
	input logic       busy_res,
	input logic       done_res,
	input logic       command_ignored
);

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("accepted item produced no result word");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> busy_res && !command_ignored)
		else $error("done without busy or together with ignored");

	a_pin_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pin_mode != 2'd3)
		else $error("undefined pin mode");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pin_mode) && $stable(busy_res))
		else $error("stalled result word changed");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd_valid),
	.cmd_stall       (cmd_stall),
	.res_valid       (res_valid),
	.res_stall       (res_stall),
	.pin_mode        (pin_mode),
	.busy_res        (busy_res),
	.done_res        (done_res),
	.command_ignored (command_ignored)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for one_wire_bus_master_core. A directed table covers
// the idle reports, busy commands, and zero-length and skipped phases. It is
// followed by random command streams under several timing register sets,
// with random gaps on both channels. Every result word is compared with a
// local prediction of the bus master.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import owbm_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ZERO_FROM_ROW  = 6;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  wv;
		logic        lvl;
		bit          any_lvl;
		int          reps;
		bit          typed;
		bus_result_t want;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	logic [1:0]           operation = OP_TICK;
	logic [7:0]           write_value = 8'h00;
	logic                 bus_level = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [1:0]           pin_mode;
	logic                 busy_res;
	logic                 done_res;
	logic [7:0]           read_data;
	logic                 device_absent;
	logic                 command_ignored;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	ticks_t boot_timing [NUM_REGS] = '{10'd480, 10'd70, 10'd410, 10'd10,
		10'd55, 10'd65, 10'd5, 10'd10};
	ticks_t timing [NUM_REGS];
	ticks_t next_timing [NUM_REGS];

	phase_t     bm_phase = PH_IDLE;
	ticks_t     bm_timer = '0;
	logic [2:0] bm_bit = '0;
	logic [7:0] bm_shift = '0;
	logic       bm_absent = 1'b0;
	logic [1:0] bm_drive = MODE_REL;
	logic [7:0] bm_last = '0;

	bus_result_t bus_reports_due [$];
	step_row_t   plan [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int words_sent = 0;
	int words_checked = 0;
	int commands_done = 0;
	int quiet_cycles = 0;

	one_wire_bus_master_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.operation       (operation),
		.write_value     (write_value),
		.bus_level       (bus_level),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.pin_mode        (pin_mode),
		.busy_res        (busy_res),
		.done_res        (done_res),
		.read_data       (read_data),
		.device_absent   (device_absent),
		.command_ignored (command_ignored),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// bus master prediction
	// ------------------------------------------------------------------
	function automatic ticks_t floor_one(input ticks_t v);
		return (v == '0) ? ticks_t'(1) : v;
	endfunction

	task automatic count_down(output logic ended);
		if (bm_timer <= ticks_t'(1)) begin
			bm_timer = '0;
			ended = 1'b1;
		end else begin
			bm_timer = bm_timer - ticks_t'(1);
			ended = 1'b0;
		end
	endtask

	task automatic begin_write_slot();
		bm_phase = PH_WR_LOW;
		bm_timer = floor_one(bm_shift[bm_bit] ? timing[REG_WR1_LOW] : timing[REG_WR0_LOW]);
		bm_drive = MODE_LOW;
	endtask

	task automatic begin_read_slot();
		bm_phase = PH_RD_LOW;
		bm_timer = READ_LOW_US;
		bm_drive = MODE_LOW;
	endtask

	task automatic end_command(input logic [1:0] mode);
		bm_phase = PH_IDLE;
		bm_timer = '0;
		bm_bit = '0;
		bm_drive = mode;
	endtask

	task automatic close_write_slot(output logic done);
		if (bm_bit == 3'd7) begin
			end_command(MODE_HIGH);
			done = 1'b1;
		end else begin
			bm_bit = bm_bit + 3'd1;
			begin_write_slot();
			done = 1'b0;
		end
	endtask

	task automatic bus_tick(input logic lvl, output logic done);
		logic   ended;
		ticks_t hi;
		done = 1'b0;
		count_down(ended);
		case (bm_phase)
			PH_RST_LOW: if (ended) begin
				bm_phase = PH_RST_WAIT;
				bm_timer = floor_one(timing[REG_PRESENCE_WAIT]);
				bm_drive = MODE_REL;
			end
			PH_RST_WAIT: if (ended) begin
				bm_absent = lvl;
				if (timing[REG_RESET_TAIL] == '0) begin
					end_command(MODE_REL);
					done = 1'b1;
				end else begin
					bm_phase = PH_RST_TAIL;
					bm_timer = timing[REG_RESET_TAIL];
				end
			end
			PH_RST_TAIL: if (ended) begin
				end_command(MODE_REL);
				done = 1'b1;
			end
			PH_WR_LOW: if (ended) begin
				hi = bm_shift[bm_bit] ? timing[REG_WR1_HIGH] : timing[REG_WR0_HIGH];
				bm_drive = MODE_HIGH;
				if (hi == '0) begin
					close_write_slot(done);
				end else begin
					bm_phase = PH_WR_HIGH;
					bm_timer = hi;
				end
			end
			PH_WR_HIGH: if (ended) begin
				close_write_slot(done);
			end
			PH_RD_LOW: if (ended) begin
				bm_phase = PH_RD_WAIT;
				bm_timer = floor_one(timing[REG_READ_SAMPLE]);
				bm_drive = MODE_REL;
			end
			PH_RD_WAIT: if (ended) begin
				if (lvl)
					bm_shift[bm_bit] = 1'b1;
				bm_phase = PH_RD_TAIL;
				bm_timer = READ_TAIL_US;
			end
			PH_RD_TAIL: if (ended) begin
				if (bm_bit == 3'd7) begin
					bm_last = bm_shift;
					end_command(MODE_REL);
					done = 1'b1;
				end else begin
					bm_bit = bm_bit + 3'd1;
					begin_read_slot();
				end
			end
			default: begin
				bm_phase = PH_IDLE;
			end
		endcase
	endtask

	task automatic bus_master_advance(input logic [1:0] op, input logic [7:0] wv,
		input logic lvl, output bus_result_t r);
		logic done;
		r = '0;
		done = 1'b0;
		if (op == OP_TICK) begin
			r.pin_mode = bm_drive;
			if (bm_phase != PH_IDLE) begin
				r.busy = 1'b1;
				bus_tick(lvl, done);
			end
		end else if (bm_phase != PH_IDLE) begin
			r.ignored = 1'b1;
			r.busy = 1'b1;
			r.pin_mode = bm_drive;
		end else begin
			bm_bit = '0;
			case (op)
				OP_RESET: begin
					bm_phase = PH_RST_LOW;
					bm_timer = floor_one(timing[REG_RESET_LOW]);
					bm_drive = MODE_LOW;
				end
				OP_WRITE: begin
					bm_shift = wv;
					begin_write_slot();
				end
				default: begin
					bm_shift = '0;
					begin_read_slot();
				end
			endcase
			r.busy = 1'b1;
			r.pin_mode = bm_drive;
		end
		r.done = done;
		r.read_data = bm_last;
		r.absent = bm_absent;
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic bus_result_t word_of(input logic [1:0] pm, input logic b,
		input logic d, input logic [7:0] rd, input logic a, input logic ig);
		bus_result_t w;
		w.pin_mode = pm;
		w.busy = b;
		w.done = d;
		w.read_data = rd;
		w.absent = a;
		w.ignored = ig;
		return w;
	endfunction

	function automatic step_row_t row(input logic [1:0] op, input logic [7:0] wv,
		input logic lvl, input bit any_lvl, input int reps, input bit typed,
		input bus_result_t want);
		step_row_t s;
		s.op = op;
		s.wv = wv;
		s.lvl = lvl;
		s.any_lvl = any_lvl;
		s.reps = reps;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [7:0] wv, input logic lvl,
		input bit have_typed, input bus_result_t typed_want);
		bus_result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		operation <= op;
		write_value <= wv;
		bus_level <= lvl;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		bus_master_advance(op, wv, lvl, want);
		bus_reports_due.push_back(have_typed ? typed_want : want);
		words_sent++;
	endtask

	task automatic finish_command();
		while (bm_phase != PH_IDLE)
			send_word(OP_TICK, 8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
	endtask

	task automatic run_command(input logic [1:0] op);
		send_word(op, 8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
		finish_command();
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (bus_reports_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic fill_timing(input int hi);
		foreach (next_timing[k])
			next_timing[k] = ticks_t'($urandom_range(hi));
	endtask

	// eight registers, then one index past the list that must be ignored
	task automatic load_timing();
		logic [REG_IDX_W-1:0] idx;
		ticks_t               val;
		settle();
		for (int k = 0; k <= NUM_REGS; k++) begin
			if (k < NUM_REGS) begin
				idx = REG_IDX_W'(k);
				val = next_timing[k];
			end else begin
				idx = REG_IDX_W'($urandom_range(15, NUM_REGS));
				val = ticks_t'($urandom);
			end
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx < NUM_REGS)
				timing[idx[REG_SEL_W-1:0]] = val;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int budget);
		int         taken;
		int         r;
		logic [1:0] op;
		taken = 0;
		while (taken < budget) begin
			r = $urandom_range(99);
			if (bm_phase == PH_IDLE) begin
				op = (r < 20) ? OP_TICK : (r < 50) ? OP_RESET : (r < 80) ? OP_WRITE : OP_READ;
				taken++;
			end else if (r < 6) begin
				op = 2'($urandom_range(3, 1));
			end else begin
				op = OP_TICK;
				taken++;
			end
			send_word(op, 8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
		end
		finish_command();
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			words_checked++;
			if (done_res)
				commands_done++;
			if (bus_reports_due.size() == 0) begin
				$error("result word with no prediction pending");
				mismatches++;
			end else begin
				want = bus_reports_due.pop_front();
				check_field("pin_mode", int'(want.pin_mode), int'(pin_mode));
				check_field("busy_res", int'(want.busy), int'(busy_res));
				check_field("done_res", int'(want.done), int'(done_res));
				check_field("read_data", int'(want.read_data), int'(read_data));
				check_field("device_absent", int'(want.absent), int'(device_absent));
				check_field("command_ignored", int'(want.ignored), int'(command_ignored));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic lvl;
		timing = boot_timing;

		// reset-default timing
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_REL, 0, 0, 8'h00, 0, 0)));
		plan.push_back(row(OP_TICK, 8'hFF, 1'b1, 0, 1, 1,
			word_of(MODE_REL, 0, 0, 8'h00, 0, 0)));
		plan.push_back(row(OP_WRITE, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 0, 0)));
		plan.push_back(row(OP_READ, 8'hFF, 1'b1, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 0, 1)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 1, 560, 0, '0));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_HIGH, 0, 0, 8'h00, 0, 0)));
		// all timing registers zero from here on
		plan.push_back(row(OP_RESET, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 0, 0)));
		plan.push_back(row(OP_RESET, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 0, 1)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b1, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 0, 0)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b1, 0, 1, 1,
			word_of(MODE_REL, 1, 1, 8'h00, 1, 0)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_REL, 0, 0, 8'h00, 1, 0)));
		plan.push_back(row(OP_WRITE, 8'hFF, 1'b0, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 1, 0)));
		plan.push_back(row(OP_WRITE, 8'h00, 1'b1, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 1, 1)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 1, 7, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 1, 0)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 1, 1, 1,
			word_of(MODE_LOW, 1, 1, 8'h00, 1, 0)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_HIGH, 0, 0, 8'h00, 1, 0)));
		plan.push_back(row(OP_RESET, 8'hFF, 1'b1, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 1, 0)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_LOW, 1, 0, 8'h00, 1, 0)));
		plan.push_back(row(OP_TICK, 8'h00, 1'b0, 0, 1, 1,
			word_of(MODE_REL, 1, 1, 8'h00, 0, 0)));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 47;
		foreach (plan[i]) begin
			if (i == ZERO_FROM_ROW) begin
				fill_timing(0);
				load_timing();
			end
			for (int n = 0; n < plan[i].reps; n++) begin
				lvl = plan[i].any_lvl ? 1'($urandom_range(1)) : plan[i].lvl;
				send_word(plan[i].op, plan[i].wv, lvl, plan[i].typed, plan[i].want);
			end
		end

		fill_timing(3);
		load_timing();
		random_phase(50);

		send_idle_pct = 47;
		recv_idle_pct = 30;
		fill_timing(15);
		load_timing();
		random_phase(50);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_timing(7);
		load_timing();
		run_command(OP_READ);
		random_phase(50);

		settle();
		$display("covered default and all-zero timing in directed rows, then random timing sets");
		$display("%0d words driven, %0d result words checked, %0d commands done, %0d mismatches",
			words_sent, words_checked, commands_done, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
